[hdl/c8x_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package c8x_pkg;

   // Geometry and sizes.
   localparam int SCREEN_WIDTH    = 64;
   localparam int SCREEN_HEIGHT   = 32;
   localparam int ROW_BYTES       = SCREEN_WIDTH / 8;
   localparam int FRAME_BYTES     = ROW_BYTES * SCREEN_HEIGHT;
   localparam int MEM_BYTES       = 4096;
   localparam int FONT_BASE       = 80;
   localparam int FONT_BYTES      = 80;
   localparam int FONT_STRIDE     = FONT_BYTES / 16;
   localparam int STACK_DEPTH_DEF = 16;
   localparam logic [11:0] RESET_PC = 12'h200;

   // Opcode sub-codes.
   localparam logic [11:0] OP_CLS       = 12'h0E0;
   localparam logic [11:0] OP_RET       = 12'h0EE;
   localparam logic [7:0]  KEY_DOWN     = 8'h9E;
   localparam logic [7:0]  KEY_UP       = 8'hA1;
   localparam logic [7:0]  FX_DELAY_RD  = 8'h07;
   localparam logic [7:0]  FX_KEY_WAIT  = 8'h0A;
   localparam logic [7:0]  FX_DELAY_WR  = 8'h15;
   localparam logic [7:0]  FX_SOUND_WR  = 8'h18;
   localparam logic [7:0]  FX_ADD_I     = 8'h1E;
   localparam logic [7:0]  FX_FONT      = 8'h29;
   localparam logic [7:0]  FX_BCD       = 8'h33;
   localparam logic [7:0]  FX_STORE     = 8'h55;
   localparam logic [7:0]  FX_LOAD      = 8'h65;
   localparam logic [3:0]  ALU_MOV      = 4'h0;
   localparam logic [3:0]  ALU_OR       = 4'h1;
   localparam logic [3:0]  ALU_AND      = 4'h2;
   localparam logic [3:0]  ALU_XOR      = 4'h3;
   localparam logic [3:0]  ALU_ADD      = 4'h4;
   localparam logic [3:0]  ALU_SUB      = 4'h5;
   localparam logic [3:0]  ALU_SHR      = 4'h6;
   localparam logic [3:0]  ALU_SUBN     = 4'h7;
   localparam logic [3:0]  ALU_SHL      = 4'hE;

   typedef enum logic [1:0] {
      REQ_EXEC, REQ_MEMWR, REQ_SCRRD, REQ_NONE
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK, ST_BADOP, ST_OVERFLOW, ST_UNDERFLOW
   } status_type;

   typedef enum logic [1:0] {
      TMR_NONE, TMR_DELAY, TMR_SOUND
   } timer_type;

   typedef enum logic [2:0] {
      CLS_SINGLE, CLS_DRAW, CLS_BCD, CLS_STORE, CLS_LOAD
   } op_class_type;

   // Datapath commands issued by the controller.
   typedef enum logic [3:0] {
      DP_IDLE, DP_LATCH, DP_DISPATCH, DP_SCR_TAKE, DP_READ_Y, DP_EXEC,
      DP_BCD, DP_STORE, DP_LOAD_ISSUE, DP_LOAD_TAKE,
      DP_DRAW_FETCH, DP_DRAW_LEFT, DP_DRAW_RIGHT, DP_DRAW_WRITE2
   } dp_op_type;

   // Status returned by the datapath.
   typedef struct packed {
      req_kind_type kind;
      op_class_type cls;
      logic         step_eq_x;
      logic         step_eq_two;
      logic         draw_done;
      logic         draw_wide;
   } dp_stat_type;

endpackage

`default_nettype wire

[hdl/c8x_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/c8x_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8x_ctrl
   import c8x_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output logic             rsp_valid,
   input  wire dp_stat_type stat,
   output dp_op_type        cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCR_TAKE, S_READ_Y, S_EXEC, S_BCD, S_STORE,
      S_LD_ISSUE, S_LD_TAKE, S_DR_FETCH, S_DR_LEFT, S_DR_RIGHT, S_DR_WRITE2
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and the command for the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = DP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = DP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd = DP_DISPATCH;
            case (stat.kind)
               REQ_EXEC:  state_in = S_READ_Y;
               REQ_SCRRD: state_in = S_SCR_TAKE;
               default:   state_in = S_IDLE;
            endcase
         end
         S_SCR_TAKE: begin
            cmd      = DP_SCR_TAKE;
            state_in = S_IDLE;
         end
         S_READ_Y: begin
            cmd      = DP_READ_Y;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd = DP_EXEC;
            case (stat.cls)
               CLS_DRAW:  state_in = S_DR_FETCH;
               CLS_BCD:   state_in = S_BCD;
               CLS_STORE: state_in = S_STORE;
               CLS_LOAD:  state_in = S_LD_ISSUE;
               default:   state_in = S_IDLE;
            endcase
         end
         S_BCD: begin
            cmd = DP_BCD;
            if (stat.step_eq_two) begin
               state_in = S_IDLE;
            end
         end
         S_STORE: begin
            cmd = DP_STORE;
            if (stat.step_eq_x) begin
               state_in = S_IDLE;
            end
         end
         S_LD_ISSUE: begin
            cmd      = DP_LOAD_ISSUE;
            state_in = S_LD_TAKE;
         end
         S_LD_TAKE: begin
            cmd      = DP_LOAD_TAKE;
            state_in = stat.step_eq_x ? S_IDLE : S_LD_ISSUE;
         end
         S_DR_FETCH: begin
            cmd      = DP_DRAW_FETCH;
            state_in = stat.draw_done ? S_IDLE : S_DR_LEFT;
         end
         S_DR_LEFT: begin
            cmd      = DP_DRAW_LEFT;
            state_in = S_DR_RIGHT;
         end
         S_DR_RIGHT: begin
            cmd      = DP_DRAW_RIGHT;
            state_in = stat.draw_wide ? S_DR_WRITE2 : S_DR_FETCH;
         end
         S_DR_WRITE2: begin
            cmd      = DP_DRAW_WRITE2;
            state_in = S_DR_FETCH;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (state_ff != S_IDLE) && (state_in == S_IDLE);
   end

   // State and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result strobe lasts one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted beat makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start work");

   // A result only follows a busy cycle.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work");

endmodule

`default_nettype wire

[hdl/c8x_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8x_dp
   import c8x_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_op_type   cmd,
   output dp_stat_type      stat,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_opcode,
   input  wire logic [11:0] req_mem_address,
   input  wire logic [7:0]  req_mem_data,
   input  wire logic [7:0]  req_screen_index,
   input  wire logic [15:0] req_key_state,
   input  wire logic [7:0]  req_random_byte,
   input  wire logic [7:0]  req_delay_now,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_next_pc,
   output logic [1:0]       rsp_timer_write,
   output logic [7:0]       rsp_timer_value,
   output logic             rsp_key_wait,
   output logic [7:0]       rsp_screen_byte
);

   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int SDW = $clog2(STACK_DEPTH + 1);
   localparam int FAW = $clog2(FRAME_BYTES);
   localparam int MAW = $clog2(MEM_BYTES);

   // Architectural state.
   logic [7:0]     vregs_ff [16];
   logic [7:0]     vregs_in [16];
   logic [15:0]    index_ff, index_in;
   logic [11:0]    pc_ff, pc_in;
   logic [11:0]    stack_ff [STACK_DEPTH];
   logic [11:0]    stack_in [STACK_DEPTH];
   logic [SDW-1:0] depth_ff, depth_in;
   logic [15:0]    seen_ff, seen_in;
   logic [FRAME_BYTES-1:0] fvld_ff, fvld_in;
   logic           fvld_rd_ff, fvld_rd_in;

   // Latched request beat.
   req_kind_type   kind_ff, kind_in;
   logic [15:0]    op_ff, op_in;
   logic [11:0]    maddr_ff, maddr_in;
   logic [7:0]     mdata_ff, mdata_in;
   logic [7:0]     sidx_ff, sidx_in;
   logic [15:0]    key_ff, key_in;
   logic [7:0]     rnd_ff, rnd_in;
   logic [7:0]     dly_ff, dly_in;

   // Working registers.
   logic [7:0]     vx_ff, vx_in;
   logic [7:0]     vy_ff, vy_in;
   logic [3:0]     step_ff, step_in;
   logic [7:0]     m_ff, m_in;
   logic [7:0]     a_ff, a_in;
   logic [7:0]     b_ff, b_in;
   logic           hit_ff, hit_in;

   // Result registers.
   status_type     res_status_ff, res_status_in;
   logic [11:0]    res_pc_ff, res_pc_in;
   timer_type      res_tw_ff, res_tw_in;
   logic [7:0]     res_tv_ff, res_tv_in;
   logic           res_kw_ff, res_kw_in;
   logic [7:0]     res_scr_ff, res_scr_in;

   // Opcode fields.
   logic [3:0]  f_x, f_y, f_n;
   logic [7:0]  f_nn;
   logic [11:0] f_nnn;
   assign f_x   = op_ff[11:8];
   assign f_y   = op_ff[7:4];
   assign f_n   = op_ff[3:0];
   assign f_nn  = op_ff[7:0];
   assign f_nnn = op_ff[11:0];

   // Single register read port.
   logic [3:0] vrd_addr;
   logic [7:0] vrd;
   always_comb begin
      case (cmd)
         DP_DISPATCH: vrd_addr = f_x;
         DP_READ_Y:   vrd_addr = (op_ff[15:12] == 4'hB) ? 4'h0 : f_y;
         default:     vrd_addr = step_ff;
      endcase
   end
   assign vrd = vregs_ff[vrd_addr];

   // Memory units.
   logic           mem_we, mem_re;
   logic [MAW-1:0] mem_waddr, mem_raddr;
   logic [7:0]     mem_wdata, mem_rdata;
   logic           fr_we, fr_re;
   logic [FAW-1:0] fr_waddr, fr_raddr;
   logic [7:0]     fr_wdata, fr_rdata, fr_val;

   c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   c8x_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_mem (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (fr_wdata),
      .rd_en   (fr_re),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   // A frame byte never written since the last clear reads as zero.
   assign fr_val = fvld_rd_ff ? fr_rdata : 8'h00;

   // Address of the current step relative to I.
   logic [11:0] maddr_i;
   assign maddr_i = index_ff[11:0] + {8'h00, step_ff};

   // Sprite geometry.
   logic [2:0]  d_col, d_sh;
   logic [4:0]  d_py, d_row;
   logic [5:0]  d_avail;
   logic [3:0]  d_rows;
   logic        d_done, d_wide;
   logic [7:0]  d_fidx, d_fidx2;
   logic [7:0]  d_b;
   logic [15:0] d_ab_sh, d_ms;
   assign d_col   = vx_ff[5:3];
   assign d_sh    = vx_ff[2:0];
   assign d_py    = vy_ff[4:0];
   assign d_avail = 6'(SCREEN_HEIGHT) - {1'b0, d_py};
   assign d_rows  = ({2'b00, f_n} > d_avail) ? d_avail[3:0] : f_n;
   assign d_done  = (step_ff == d_rows);
   assign d_wide  = (d_sh != 3'd0) && (d_col != 3'd7);
   assign d_row   = d_py + {1'b0, step_ff};
   assign d_fidx  = {d_row, d_col};
   assign d_fidx2 = {d_row, d_col + 3'd1};
   assign d_b     = d_wide ? fr_val : 8'h00;
   assign d_ab_sh = {a_ff, d_b} << d_sh;
   assign d_ms    = {m_ff, 8'h00} >> d_sh;

   // Decimal digits for the BCD store.
   logic [1:0]  bcd_hund;
   logic [7:0]  bcd_sub;
   logic [6:0]  bcd_rem;
   logic [14:0] bcd_prod;
   logic [3:0]  bcd_tens, bcd_ones;
   logic [7:0]  bcd_digit;
   always_comb begin
      if (vx_ff >= 8'd200) begin
         bcd_hund = 2'd2;
         bcd_sub  = 8'd200;
      end else if (vx_ff >= 8'd100) begin
         bcd_hund = 2'd1;
         bcd_sub  = 8'd100;
      end else begin
         bcd_hund = 2'd0;
         bcd_sub  = 8'd0;
      end
      bcd_rem  = 7'(vx_ff - bcd_sub);
      bcd_prod = {8'h00, bcd_rem} * 15'd205;
      bcd_tens = bcd_prod[14:11];
      bcd_ones = 4'(bcd_rem - {3'b000, bcd_tens} * 7'd10);
      case (step_ff[1:0])
         2'd0:    bcd_digit = {6'b0, bcd_hund};
         2'd1:    bcd_digit = {4'b0, bcd_tens};
         default: bcd_digit = {4'b0, bcd_ones};
      endcase
   end

   // Key wait: first key that was seen and is now released.
   logic [15:0] kw_pend;
   logic        kw_found;
   logic [3:0]  kw_idx;
   always_comb begin
      kw_pend  = ~key_ff & seen_ff;
      kw_found = |kw_pend;
      kw_idx   = 4'h0;
      for (int i = 15; i >= 0; i--) begin
         if (kw_pend[i]) begin
            kw_idx = 4'(i);
         end
      end
   end

   // Stack indexes.
   logic [SDW-1:0] depth_m1;
   logic [SIW-1:0] pop_idx, push_idx;
   assign depth_m1 = depth_ff - SDW'(1);
   assign pop_idx  = depth_m1[SIW-1:0];
   assign push_idx = depth_ff[SIW-1:0];

   // Combinational execute logic for one opcode.
   logic [11:0] pc2, pc4;
   logic [8:0]  sum9;
   logic        key_bit;
   status_type  ex_status;
   logic [11:0] ex_pc;
   timer_type   ex_tw;
   logic [7:0]  ex_tv;
   logic        ex_kw;
   logic        ex_vx_we, ex_vf_we, ex_i_we, ex_push, ex_pop, ex_cls, ex_seen_we;
   logic [7:0]  ex_vx_wd, ex_vf_wd;
   logic [15:0] ex_i_wd, ex_seen_wd;
   op_class_type ex_class;

   assign pc2     = pc_ff + 12'd2;
   assign pc4     = pc_ff + 12'd4;
   assign sum9    = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign key_bit = key_ff[vx_ff[3:0]];

   always_comb begin
      ex_status  = ST_OK;
      ex_pc      = pc2;
      ex_tw      = TMR_NONE;
      ex_tv      = 8'h00;
      ex_kw      = 1'b0;
      ex_vx_we   = 1'b0;
      ex_vx_wd   = 8'h00;
      ex_vf_we   = 1'b0;
      ex_vf_wd   = 8'h00;
      ex_i_we    = 1'b0;
      ex_i_wd    = index_ff;
      ex_push    = 1'b0;
      ex_pop     = 1'b0;
      ex_cls     = 1'b0;
      ex_seen_we = 1'b0;
      ex_seen_wd = seen_ff;
      case (op_ff[15:12])
         4'h0: begin
            if (f_nnn == OP_CLS) begin
               ex_cls = 1'b1;
            end else if (f_nnn == OP_RET) begin
               if (depth_ff == '0) begin
                  ex_status = ST_UNDERFLOW;
               end else begin
                  ex_pop = 1'b1;
                  ex_pc  = stack_ff[pop_idx];
               end
            end else begin
               ex_status = ST_BADOP;
            end
         end
         4'h1: ex_pc = f_nnn;
         4'h2: begin
            if (depth_ff >= SDW'(STACK_DEPTH)) begin
               ex_status = ST_OVERFLOW;
            end else begin
               ex_push = 1'b1;
               ex_pc   = f_nnn;
            end
         end
         4'h3: if (vx_ff == f_nn) ex_pc = pc4;
         4'h4: if (vx_ff != f_nn) ex_pc = pc4;
         4'h5: begin
            if (f_n != 4'h0) begin
               ex_status = ST_BADOP;
            end else if (vx_ff == vy_ff) begin
               ex_pc = pc4;
            end
         end
         4'h6: begin
            ex_vx_we = 1'b1;
            ex_vx_wd = f_nn;
         end
         4'h7: begin
            ex_vx_we = 1'b1;
            ex_vx_wd = vx_ff + f_nn;
         end
         4'h8: begin
            ex_vx_we = 1'b1;
            case (f_n)
               ALU_MOV: ex_vx_wd = vy_ff;
               ALU_OR:  ex_vx_wd = vx_ff | vy_ff;
               ALU_AND: ex_vx_wd = vx_ff & vy_ff;
               ALU_XOR: ex_vx_wd = vx_ff ^ vy_ff;
               ALU_ADD: begin
                  ex_vx_wd = sum9[7:0];
                  ex_vf_we = 1'b1;
                  ex_vf_wd = {7'b0, sum9[8]};
               end
               ALU_SUB: begin
                  ex_vx_wd = vx_ff - vy_ff;
                  ex_vf_we = 1'b1;
                  ex_vf_wd = {7'b0, vx_ff >= vy_ff};
               end
               ALU_SHR: begin
                  ex_vx_wd = vx_ff >> 1;
                  ex_vf_we = 1'b1;
                  ex_vf_wd = {7'b0, vx_ff[0]};
               end
               ALU_SUBN: begin
                  ex_vx_wd = vy_ff - vx_ff;
                  ex_vf_we = 1'b1;
                  ex_vf_wd = {7'b0, vy_ff >= vx_ff};
               end
               ALU_SHL: begin
                  ex_vx_wd = vx_ff << 1;
                  ex_vf_we = 1'b1;
                  ex_vf_wd = {7'b0, vx_ff[7]};
               end
               default: ex_status = ST_BADOP;
            endcase
         end
         4'h9: begin
            if (f_n != 4'h0) begin
               ex_status = ST_BADOP;
            end else if (vx_ff != vy_ff) begin
               ex_pc = pc4;
            end
         end
         4'hA: begin
            ex_i_we = 1'b1;
            ex_i_wd = {4'h0, f_nnn};
         end
         // The second register read holds V0 for a relative jump.
         4'hB: ex_pc = {4'h0, vy_ff} + f_nnn;
         4'hC: begin
            ex_vx_we = 1'b1;
            ex_vx_wd = rnd_ff & f_nn;
         end
         4'hD: ex_pc = pc2;
         4'hE: begin
            if (f_nn == KEY_DOWN) begin
               if (key_bit) ex_pc = pc4;
            end else if (f_nn == KEY_UP) begin
               if (!key_bit) ex_pc = pc4;
            end else begin
               ex_status = ST_BADOP;
            end
         end
         default: begin
            case (f_nn)
               FX_DELAY_RD: begin
                  ex_vx_we = 1'b1;
                  ex_vx_wd = dly_ff;
               end
               FX_KEY_WAIT: begin
                  ex_seen_we = 1'b1;
                  if (kw_found) begin
                     ex_vx_we   = 1'b1;
                     ex_vx_wd   = {4'h0, kw_idx};
                     ex_seen_wd = 16'h0000;
                  end else begin
                     ex_pc      = pc_ff;
                     ex_kw      = 1'b1;
                     ex_seen_wd = seen_ff | key_ff;
                  end
               end
               FX_DELAY_WR: begin
                  ex_tw = TMR_DELAY;
                  ex_tv = vx_ff;
               end
               FX_SOUND_WR: begin
                  ex_tw = TMR_SOUND;
                  ex_tv = vx_ff;
               end
               FX_ADD_I: begin
                  ex_i_we = 1'b1;
                  ex_i_wd = index_ff + {8'h00, vx_ff};
               end
               FX_FONT: begin
                  ex_i_we = 1'b1;
                  ex_i_wd = 16'(FONT_BASE) + {12'h000, vx_ff[3:0]} * 16'(FONT_STRIDE);
               end
               FX_BCD, FX_STORE, FX_LOAD: ex_pc = pc2;
               default: ex_status = ST_BADOP;
            endcase
         end
      endcase
   end

   // Opcodes that walk memory step by step.
   always_comb begin
      if (op_ff[15:12] == 4'hD) begin
         ex_class = CLS_DRAW;
      end else if (op_ff[15:12] == 4'hF && f_nn == FX_BCD) begin
         ex_class = CLS_BCD;
      end else if (op_ff[15:12] == 4'hF && f_nn == FX_STORE) begin
         ex_class = CLS_STORE;
      end else if (op_ff[15:12] == 4'hF && f_nn == FX_LOAD) begin
         ex_class = CLS_LOAD;
      end else begin
         ex_class = CLS_SINGLE;
      end
   end

   assign stat.kind        = kind_ff;
   assign stat.cls         = ex_class;
   assign stat.step_eq_x   = (step_ff == f_x);
   assign stat.step_eq_two = (step_ff == 4'd2);
   assign stat.draw_done   = d_done;
   assign stat.draw_wide   = d_wide;

   // Memory port control.
   always_comb begin
      mem_we    = ((cmd == DP_DISPATCH) && (kind_ff == REQ_MEMWR))
                  || (cmd == DP_BCD) || (cmd == DP_STORE);
      mem_waddr = (cmd == DP_DISPATCH) ? maddr_ff : maddr_i;
      if (cmd == DP_DISPATCH) begin
         mem_wdata = mdata_ff;
      end else if (cmd == DP_BCD) begin
         mem_wdata = bcd_digit;
      end else begin
         mem_wdata = vrd;
      end
      mem_re    = (cmd == DP_LOAD_ISSUE) || ((cmd == DP_DRAW_FETCH) && !d_done);
      mem_raddr = maddr_i;

      fr_re     = ((cmd == DP_DISPATCH) && (kind_ff == REQ_SCRRD))
                  || ((cmd == DP_DRAW_FETCH) && !d_done) || (cmd == DP_DRAW_LEFT);
      if (cmd == DP_DISPATCH) begin
         fr_raddr = sidx_ff;
      end else if (cmd == DP_DRAW_LEFT) begin
         fr_raddr = d_fidx2;
      end else begin
         fr_raddr = d_fidx;
      end
      fr_we     = (cmd == DP_DRAW_RIGHT) || (cmd == DP_DRAW_WRITE2);
      fr_waddr  = (cmd == DP_DRAW_RIGHT) ? d_fidx : d_fidx2;
      fr_wdata  = (cmd == DP_DRAW_RIGHT) ? (a_ff ^ d_ms[15:8]) : (b_ff ^ d_ms[7:0]);
   end

   // Next-state logic for all registers.
   logic ex_go;
   assign ex_go = (cmd == DP_EXEC) && (ex_status == ST_OK);

   always_comb begin
      vregs_in      = vregs_ff;
      index_in      = index_ff;
      pc_in         = pc_ff;
      stack_in      = stack_ff;
      depth_in      = depth_ff;
      seen_in       = seen_ff;
      fvld_in       = fvld_ff;
      fvld_rd_in    = fvld_ff[fr_raddr];
      kind_in       = kind_ff;
      op_in         = op_ff;
      maddr_in      = maddr_ff;
      mdata_in      = mdata_ff;
      sidx_in       = sidx_ff;
      key_in        = key_ff;
      rnd_in        = rnd_ff;
      dly_in        = dly_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      step_in       = step_ff;
      m_in          = m_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_pc_in     = res_pc_ff;
      res_tw_in     = res_tw_ff;
      res_tv_in     = res_tv_ff;
      res_kw_in     = res_kw_ff;
      res_scr_in    = res_scr_ff;

      case (cmd)
         // Take the request beat and preset the result.
         DP_LATCH: begin
            kind_in       = req_kind_type'(req_type);
            op_in         = req_opcode;
            maddr_in      = req_mem_address;
            mdata_in      = req_mem_data;
            sidx_in       = req_screen_index;
            key_in        = req_key_state;
            rnd_in        = req_random_byte;
            dly_in        = req_delay_now;
            res_status_in = ST_OK;
            res_pc_in     = pc_ff;
            res_tw_in     = TMR_NONE;
            res_tv_in     = 8'h00;
            res_kw_in     = 1'b0;
            res_scr_in    = 8'h00;
         end
         DP_DISPATCH: vx_in = vrd;
         DP_SCR_TAKE: res_scr_in = fr_val;
         DP_READ_Y:   vy_in = vrd;
         DP_EXEC: begin
            res_status_in = ex_status;
            step_in       = 4'h0;
            hit_in        = 1'b0;
            if (ex_go) begin
               pc_in     = ex_pc;
               res_pc_in = ex_pc;
               res_tw_in = ex_tw;
               res_tv_in = ex_tv;
               res_kw_in = ex_kw;
               if (ex_vx_we) vregs_in[f_x] = ex_vx_wd;
               if (ex_vf_we) vregs_in[15]  = ex_vf_wd;
               if (ex_i_we)  index_in      = ex_i_wd;
               if (ex_seen_we) seen_in     = ex_seen_wd;
               if (ex_cls)   fvld_in       = '0;
               if (ex_push) begin
                  stack_in[push_idx] = pc2;
                  depth_in           = depth_ff + SDW'(1);
               end
               if (ex_pop) begin
                  depth_in = depth_m1;
               end
            end
         end
         DP_BCD, DP_STORE: step_in = step_ff + 4'd1;
         DP_LOAD_TAKE: begin
            vregs_in[step_ff] = mem_rdata;
            step_in           = step_ff + 4'd1;
         end
         DP_DRAW_FETCH: begin
            if (d_done) begin
               vregs_in[15] = {7'b0, hit_ff};
            end
         end
         DP_DRAW_LEFT: begin
            m_in = mem_rdata;
            a_in = fr_val;
         end
         DP_DRAW_RIGHT: begin
            b_in   = d_b;
            hit_in = hit_ff | (|(d_ab_sh[15:8] & m_ff));
            if (!d_wide) begin
               step_in = step_ff + 4'd1;
            end
         end
         DP_DRAW_WRITE2: step_in = step_ff + 4'd1;
         default: begin
         end
      endcase

      if (fr_we) begin
         fvld_in[fr_waddr] = 1'b1;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            vregs_ff[i] <= 8'h00;
         end
         index_ff <= 16'h0000;
         pc_ff    <= RESET_PC;
         depth_ff <= '0;
         seen_ff  <= 16'h0000;
         fvld_ff  <= '0;
      end else begin
         vregs_ff <= vregs_in;
         index_ff <= index_in;
         pc_ff    <= pc_in;
         depth_ff <= depth_in;
         seen_ff  <= seen_in;
         fvld_ff  <= fvld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stack_ff      <= stack_in;
      fvld_rd_ff    <= fvld_rd_in;
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      maddr_ff      <= maddr_in;
      mdata_ff      <= mdata_in;
      sidx_ff       <= sidx_in;
      key_ff        <= key_in;
      rnd_ff        <= rnd_in;
      dly_ff        <= dly_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      step_ff       <= step_in;
      m_ff          <= m_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_pc_ff     <= res_pc_in;
      res_tw_ff     <= res_tw_in;
      res_tv_ff     <= res_tv_in;
      res_kw_ff     <= res_kw_in;
      res_scr_ff    <= res_scr_in;
   end

   assign rsp_status      = res_status_ff;
   assign rsp_next_pc     = res_pc_ff;
   assign rsp_timer_write = res_tw_ff;
   assign rsp_timer_value = res_tv_ff;
   assign rsp_key_wait    = res_kw_ff;
   assign rsp_screen_byte = res_scr_ff;

   // The return stack never holds more than its depth.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= SDW'(STACK_DEPTH))
      else $error("return stack depth out of range");

   // The right-hand sprite write always follows the left-hand one.
   a_draw_order: assert property (@(posedge clock) disable iff (reset)
      (cmd == DP_DRAW_WRITE2) |-> ($past(cmd) == DP_DRAW_RIGHT))
      else $error("sprite write out of order");

   // Main memory is never written and read in the same cycle.
   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !mem_re)
      else $error("main memory read and write collide");

endmodule

`default_nettype wire

[hdl/chip8_instruction_executor.sv]
// Channel   Direction  Handshake                      Payload
// request   in         start high while busy low      req_type, req_opcode, req_mem_*, ...
// result    out        rsp_valid high for one cycle    rsp_status, rsp_next_pc, rsp_*
//
// A memory write or an unused request type completes at dispatch, a screen read after a
// frame-store read, a plain opcode after a second register read and execution. FX33 then
// writes three digits, FX55 stores V0..VX, FX65 loads V0..VX, and DXYN fetches, reads and
// writes each drawn row, plus a second byte where the row spans two. Reset is synchronous
// and leaves PC at 0x200 with registers, stack depth, key history and screen clear; program
// memory is not cleared. The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module chip8_instruction_executor
   import c8x_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_opcode,
   input  wire logic [11:0] req_mem_address,
   input  wire logic [7:0]  req_mem_data,
   input  wire logic [7:0]  req_screen_index,
   input  wire logic [15:0] req_key_state,
   input  wire logic [7:0]  req_random_byte,
   input  wire logic [7:0]  req_delay_now,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_next_pc,
   output logic [1:0]       rsp_timer_write,
   output logic [7:0]       rsp_timer_value,
   output logic             rsp_key_wait,
   output logic [7:0]       rsp_screen_byte
);

   dp_op_type   cmd;
   dp_stat_type stat;

   // Sequencer.
   c8x_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Registers, stack, memories and execution logic.
   c8x_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_opcode       (req_opcode),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .req_screen_index (req_screen_index),
      .req_key_state    (req_key_state),
      .req_random_byte  (req_random_byte),
      .req_delay_now    (req_delay_now),
      .rsp_status       (rsp_status),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_timer_write  (rsp_timer_write),
      .rsp_timer_value  (rsp_timer_value),
      .rsp_key_wait     (rsp_key_wait),
      .rsp_screen_byte  (rsp_screen_byte)
   );

endmodule

`default_nettype wire
